// File: design/tile_background_window_pixel_unit_macros.svh
// Assertion macros shared by the checker of the tile background and window pixel unit.
`ifndef TILE_BACKGROUND_WINDOW_PIXEL_UNIT_MACROS_SVH
`define TILE_BACKGROUND_WINDOW_PIXEL_UNIT_MACROS_SVH

// Same-cycle implication, switched off while dis is true.
`define TBW_ASSERT_NOW(label, clk, dis, cond, expr) \
    label: assert property (@(posedge clk) disable iff (dis) (cond) |-> (expr)) \
        else $error("tbw check failed");

// Next-cycle implication, switched off while dis is true.
`define TBW_ASSERT_NEXT(label, clk, dis, cond, expr) \
    label: assert property (@(posedge clk) disable iff (dis) (cond) |=> (expr)) \
        else $error("tbw check failed");

`endif

// File: design/tbw_pkg.sv
// Types, constants and helper functions of the tile background and window pixel unit.
`timescale 1ns / 1ps
package tbw_pkg;

    localparam int VMEM_AW = 13;
    localparam int BANK_AW = VMEM_AW - 1;
    localparam int CFG_IW  = 3;

    // Item actions
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_RENDER = 1'b1;

    // Register indexes
    localparam logic [CFG_IW-1:0] CFG_LCD_CONTROL = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_SCROLL_X    = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_SCROLL_Y    = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_WIN_X_POS   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_WIN_Y_POS   = 3'd4;

    // Control register bits
    localparam int LCDC_BG_EN    = 0;
    localparam int LCDC_BG_MAP   = 3;
    localparam int LCDC_TILE_MODE = 4;
    localparam int LCDC_WIN_EN   = 5;
    localparam int LCDC_WIN_MAP  = 6;

    localparam logic [VMEM_AW-1:0] MAP_LOW  = 13'h1800;
    localparam logic [VMEM_AW-1:0] MAP_HIGH = 13'h1C00;

    localparam logic [7:0] WIN_OFFSET = 8'd7;

    typedef struct packed {
        logic       action;
        logic [12:0] mem_address;
        logic [7:0] mem_data;
        logic [7:0] screen_line;
        logic [7:0] screen_column;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  pixel_line;
        logic [7:0]  pixel_column;
        logic [1:0]  color_index;
        logic        from_window;
        logic [31:0] argb;
    } t_out_item;

    typedef struct packed {
        logic [7:0] lcd_control;
        logic [7:0] scroll_x;
        logic [7:0] scroll_y;
        logic [7:0] win_x_pos;
        logic [7:0] win_y_pos;
    } t_cfg;

    typedef struct packed {
        logic               wr_en;
        logic [VMEM_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
        logic               map_rd;
        logic [VMEM_AW-1:0] map_addr;
        logic               tile_rd;
        logic [BANK_AW-1:0] tile_idx;
    } t_vram_req;

    typedef struct packed {
        logic       busy;
        logic [7:0] map_byte;
        logic [7:0] plane_lo;
        logic [7:0] plane_hi;
    } t_vram_rsp;

    function automatic logic [31:0] shade(input logic [1:0] color);
        logic [31:0] s;
        case (color)
            2'd0: s = 32'hFF9BBC0F;
            2'd1: s = 32'hFF8BAC0F;
            2'd2: s = 32'hFF306230;
            2'd3: s = 32'hFF0F380F;
            default: s = 32'hFF9BBC0F;
        endcase
        return s;
    endfunction

endpackage

// File: design/tbw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module tbw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/tbw_cfg.sv
// Configuration register file of the tile background and window pixel unit.
`timescale 1ns / 1ps
module tbw_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tbw_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [7:0]                 i_cfg_data,
    output tbw_pkg::t_cfg              o_cfg
);
    import tbw_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LCD_CONTROL: r_cfg.lcd_control <= i_cfg_data;
                CFG_SCROLL_X:    r_cfg.scroll_x    <= i_cfg_data;
                CFG_SCROLL_Y:    r_cfg.scroll_y    <= i_cfg_data;
                CFG_WIN_X_POS:   r_cfg.win_x_pos   <= i_cfg_data;
                CFG_WIN_Y_POS:   r_cfg.win_y_pos   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/tbw_vram.sv
// Video memory: two byte banks split on address bit 0, with a clearing sweep after reset.
`timescale 1ns / 1ps
module tbw_vram (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tbw_pkg::t_vram_req i_req,
    output tbw_pkg::t_vram_rsp o_rsp
);
    import tbw_pkg::*;

    logic               r_clr_active;
    logic [BANK_AW-1:0] r_clr_idx;
    logic               r_map_bank;

    logic               we_even;
    logic               we_odd;
    logic [BANK_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               re_even;
    logic               re_odd;
    logic [BANK_AW-1:0] raddr;
    logic [7:0]         q_even;
    logic [7:0]         q_odd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_idx    <= '0;
            r_map_bank   <= 1'b0;
        end else begin
            if (r_clr_active) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == {BANK_AW{1'b1}}) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (i_req.map_rd) begin
                r_map_bank <= i_req.map_addr[0];
            end
        end
    end

    // The sweep writes both banks at once; no item is taken while it runs.
    always_comb begin
        if (r_clr_active) begin
            we_even = 1'b1;
            we_odd  = 1'b1;
            waddr   = r_clr_idx;
            wdata   = 8'd0;
        end else begin
            we_even = i_req.wr_en && !i_req.wr_addr[0];
            we_odd  = i_req.wr_en && i_req.wr_addr[0];
            waddr   = i_req.wr_addr[VMEM_AW-1:1];
            wdata   = i_req.wr_data;
        end
    end

    // Plane bytes sit at an even address and the next odd one, so a tile
    // row reads the same index in both banks.
    always_comb begin
        if (i_req.tile_rd) begin
            re_even = 1'b1;
            re_odd  = 1'b1;
            raddr   = i_req.tile_idx;
        end else begin
            re_even = i_req.map_rd && !i_req.map_addr[0];
            re_odd  = i_req.map_rd && i_req.map_addr[0];
            raddr   = i_req.map_addr[VMEM_AW-1:1];
        end
    end

    tbw_ram #(.WIDTH(8), .DEPTH(1 << BANK_AW)) u_bank_even (
        .i_clk   (i_clk),
        .i_we    (we_even),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re_even),
        .i_raddr (raddr),
        .o_rdata (q_even)
    );

    tbw_ram #(.WIDTH(8), .DEPTH(1 << BANK_AW)) u_bank_odd (
        .i_clk   (i_clk),
        .i_we    (we_odd),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re_odd),
        .i_raddr (raddr),
        .o_rdata (q_odd)
    );

    assign o_rsp.busy     = r_clr_active;
    assign o_rsp.map_byte = r_map_bank ? q_odd : q_even;
    assign o_rsp.plane_lo = q_even;
    assign o_rsp.plane_hi = q_odd;

endmodule

// File: design/tile_background_window_pixel_unit.sv
// Top level of the tile background and window pixel unit.
`timescale 1ns / 1ps
// Input channel (i_in_valid / o_in_stall / i_in_data): each item either writes
// one byte of the 8 KiB video memory or asks for the pixel at (line, column).
// Output channel (o_out_valid / i_out_stall / o_out_data): one item per
// rendered pixel with its colour index, layer flag and ARGB shade.
// Configuration: i_cfg_we writes register i_cfg_index with i_cfg_data; write
// it only while no item is in flight.
// A pixel item reads its tile map entry in the cycle it is accepted and the
// two plane bytes in the next one if the plane stage is free; its result then
// moves on into the output register. The banks' single read port admits no
// pixel item while one is in the tile stage; write items and dropped pixel
// items go in one a cycle while no pixel item waits in the tile or plane stage.
// After reset the video memory is swept to zero (both banks at once); no item
// is accepted during the sweep.
// If the output is stalled a finished result waits in the output register;
// the next pixel item then holds in the plane stage and the input stalls.
module tile_background_window_pixel_unit #(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 144
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  tbw_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output tbw_pkg::t_out_item         o_out_data,
    input  logic                       i_cfg_we,
    input  logic [tbw_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [7:0]                 i_cfg_data
);
    import tbw_pkg::*;

    localparam logic [8:0] WIDTH_9   = 9'(SCREEN_WIDTH);
    localparam logic [8:0] HEIGHT_9  = 9'(SCREEN_HEIGHT);
    localparam logic [9:0] WIN_LIMIT = 10'(SCREEN_WIDTH + 7);
    localparam logic [8:0] LAST_COL  = 9'(SCREEN_WIDTH - 1);

    t_cfg      cfg;
    t_vram_req vreq;
    t_vram_rsp vrsp;

    logic       in_acc;
    logic       render;
    logic       win_vis;
    logic       win_hit;
    logic [7:0] row_cur;
    logic [8:0] wx_full;
    logic [7:0] tx;
    logic [7:0] ty;
    logic       map_sel;
    logic       s1_go;
    logic       s2_adv;
    logic       s2_free;
    logic [1:0] color;

    logic [7:0] r_win_row;
    logic [7:0] n_win_row;

    logic       r_s1_valid;
    logic [7:0] r_s1_line;
    logic [7:0] r_s1_col;
    logic       r_s1_win;
    logic [2:0] r_s1_fx;
    logic [2:0] r_s1_fy;

    logic       r_s2_valid;
    logic [7:0] r_s2_line;
    logic [7:0] r_s2_col;
    logic       r_s2_win;
    logic [2:0] r_s2_fx;

    logic       r_out_valid;
    t_out_item  r_out_data;

    tbw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tbw_vram u_vram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (vreq),
        .o_rsp   (vrsp)
    );

    assign s2_adv  = r_s2_valid && (!r_out_valid || !i_out_stall);
    assign s2_free = !r_s2_valid || s2_adv;
    assign s1_go   = r_s1_valid && s2_free;

    assign o_in_stall = vrsp.busy || r_s1_valid || (r_s2_valid && !s2_adv);
    assign in_acc     = i_in_valid && !o_in_stall;

    // Address stage: pick the layer and form the map entry address.
    always_comb begin
        render = in_acc && (i_in_data.action == ACT_RENDER)
                 && ({1'b0, i_in_data.screen_line} < HEIGHT_9)
                 && ({1'b0, i_in_data.screen_column} < WIDTH_9)
                 && cfg.lcd_control[LCDC_BG_EN];
        row_cur = (i_in_data.screen_line == 8'd0) ? 8'd0 : r_win_row;
        win_vis = cfg.lcd_control[LCDC_WIN_EN]
                  && (i_in_data.screen_line >= cfg.win_y_pos)
                  && ({2'b00, cfg.win_x_pos} < WIN_LIMIT);
        win_hit = win_vis && (({1'b0, i_in_data.screen_column} + {1'b0, WIN_OFFSET})
                              >= {1'b0, cfg.win_x_pos});
        wx_full = {1'b0, i_in_data.screen_column} + {1'b0, WIN_OFFSET}
                  - {1'b0, cfg.win_x_pos};
        if (win_hit) begin
            tx      = wx_full[7:0];
            ty      = row_cur;
            map_sel = cfg.lcd_control[LCDC_WIN_MAP];
        end else begin
            tx      = i_in_data.screen_column + cfg.scroll_x;
            ty      = i_in_data.screen_line + cfg.scroll_y;
            map_sel = cfg.lcd_control[LCDC_BG_MAP];
        end

        n_win_row = r_win_row;
        if (render) begin
            if (win_vis && ({1'b0, i_in_data.screen_column} == LAST_COL)) begin
                n_win_row = row_cur + 8'd1;
            end else begin
                n_win_row = row_cur;
            end
        end
    end

    always_comb begin
        vreq.wr_en    = in_acc && (i_in_data.action == ACT_WRITE);
        vreq.wr_addr  = i_in_data.mem_address;
        vreq.wr_data  = i_in_data.mem_data;
        vreq.map_rd   = render;
        vreq.map_addr = (map_sel ? MAP_HIGH : MAP_LOW) + {3'b000, ty[7:3], tx[7:3]};
        vreq.tile_rd  = s1_go;
        // In signed mode indexes 0 to 127 land in the upper tile block.
        vreq.tile_idx = {cfg.lcd_control[LCDC_TILE_MODE] ? 1'b0 : ~vrsp.map_byte[7],
                         vrsp.map_byte, r_s1_fy};
    end

    assign color = {vrsp.plane_hi[3'd7 - r_s2_fx], vrsp.plane_lo[3'd7 - r_s2_fx]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_row   <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_win_row <= n_win_row;

            if (render) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_go) begin
                r_s2_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end

            if (s2_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (render) begin
            r_s1_line <= i_in_data.screen_line;
            r_s1_col  <= i_in_data.screen_column;
            r_s1_win  <= win_hit;
            r_s1_fx   <= tx[2:0];
            r_s1_fy   <= ty[2:0];
        end
        if (s1_go) begin
            r_s2_line <= r_s1_line;
            r_s2_col  <= r_s1_col;
            r_s2_win  <= r_s1_win;
            r_s2_fx   <= r_s1_fx;
        end
        if (s2_adv) begin
            r_out_data.pixel_line   <= r_s2_line;
            r_out_data.pixel_column <= r_s2_col;
            r_out_data.color_index  <= color;
            r_out_data.from_window  <= r_s2_win;
            r_out_data.argb         <= shade(color);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: design/tbw_checker.sv
// Port-level checker of the tile background and window pixel unit and its bind.
`timescale 1ns / 1ps
`include "tile_background_window_pixel_unit_macros.svh"
module tbw_checker #(
    parameter int SCREEN_WIDTH  = 160,
    parameter int SCREEN_HEIGHT = 144
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input tbw_pkg::t_in_item          i_in_data,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input tbw_pkg::t_out_item         o_out_data,
    input logic                       i_cfg_we,
    input logic [tbw_pkg::CFG_IW-1:0] i_cfg_index,
    input logic [7:0]                 i_cfg_data
);
    import tbw_pkg::*;

    localparam logic [8:0] HEIGHT_9 = 9'(SCREEN_HEIGHT);
    localparam logic [8:0] WIDTH_9  = 9'(SCREEN_WIDTH);

    logic pix_acc;
    logic cfg_seen;
    logic r_bg_on;

    // Background enable as last written through the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg_on <= 1'b0;
        end else if (i_cfg_we && (i_cfg_index == CFG_LCD_CONTROL)) begin
            r_bg_on <= i_cfg_data[LCDC_BG_EN];
        end
    end

    // Only pixel items that are actually rendered occupy the map stage.
    assign pix_acc  = i_in_valid && !o_in_stall && (i_in_data.action == ACT_RENDER)
                      && ({1'b0, i_in_data.screen_line} < HEIGHT_9)
                      && ({1'b0, i_in_data.screen_column} < WIDTH_9)
                      && r_bg_on;
    assign cfg_seen = i_cfg_we && (i_cfg_index == CFG_LCD_CONTROL) && (i_cfg_data == 8'd0);

    // The memory sweep starts straight out of reset.
    `TBW_ASSERT_NEXT(a_sweep_after_reset, i_clk, 1'b0, !i_rst_n, o_in_stall)
    // Pixel items share the memory read port, so none follows in the next cycle.
    `TBW_ASSERT_NEXT(a_pixel_spacing, i_clk, !i_rst_n, pix_acc, o_in_stall)
    `TBW_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_out_valid && i_out_stall,
                     o_out_valid && $stable(o_out_data))
    `TBW_ASSERT_NOW(a_shade_match, i_clk, !i_rst_n, o_out_valid,
                    o_out_data.argb == shade(o_out_data.color_index))
    `TBW_ASSERT_NOW(a_pixel_in_screen, i_clk, !i_rst_n || cfg_seen, o_out_valid,
                    ({1'b0, o_out_data.pixel_line} < HEIGHT_9)
                    && ({1'b0, o_out_data.pixel_column} < WIDTH_9))

endmodule

bind tile_background_window_pixel_unit tbw_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tbw_checker (.*);
